// ===== hw/rtl/deadman_operator_supervisor_assert.svh =====
// Assertion macros shared by the deadman operator supervisor RTL
`ifndef DEADMAN_OPERATOR_SUPERVISOR_ASSERT_SVH
`define DEADMAN_OPERATOR_SUPERVISOR_ASSERT_SVH

// same-cycle implication, checked on every rising clock outside reset
`define DOS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DOS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/dos_pkg.sv =====
// Package: types, constants and helpers of the deadman operator supervisor
`timescale 1ns / 1ps
package dos_pkg;

   localparam int TIMER_BITS = 16;

   typedef logic [TIMER_BITS-1:0] timer_type;
   typedef logic [15:0]           ticks_type;
   typedef logic [3:0]            count_type;
   typedef logic [6:0]            speed_type;
   typedef logic [9:0]            green_type;
   typedef logic [14:0]           hz_type;
   typedef logic [15:0]           csr_data_type;
   typedef logic [21:0]           tone_prod_type;

   typedef enum logic [2:0] {
      CSR_STABLE_SAMPLES = 3'd0,
      CSR_DOUBLE_TAP     = 3'd1,
      CSR_SPEED_REPORT   = 3'd2,
      CSR_ALIVE_REPORT   = 3'd3,
      CSR_ACK_RETRY      = 3'd4,
      CSR_BEEP_TOGGLE    = 3'd5,
      CSR_TONE_MIN       = 3'd6,
      CSR_TONE_MAX       = 3'd7
   } csr_index_type;

   typedef struct packed {
      count_type stable_samples;
      ticks_type double_tap_ticks;
      ticks_type speed_report_ticks;
      ticks_type alive_report_ticks;
      ticks_type ack_retry_ticks;
      ticks_type beep_toggle_ticks;
      hz_type    tone_min_hz;
      hz_type    tone_max_hz;
   } cfg_type;

   typedef struct packed {
      logic      red_led;
      logic      blue_led;
      green_type green_level;
      logic      buzzer_enable;
      hz_type    buzzer_hz;
      logic      send_ready_event;
      logic      send_stop_event;
      logic      send_emergency;
      logic      send_speed;
      speed_type speed_value;
      logic      send_alive;
   } rsp_data_type;

   localparam count_type STABLE_SAMPLES_RESET = 4'd3;
   localparam ticks_type DOUBLE_TAP_RESET     = 16'd20;
   localparam ticks_type SPEED_REPORT_RESET   = 16'd10;
   localparam ticks_type ALIVE_REPORT_RESET   = 16'd50;
   localparam ticks_type ACK_RETRY_RESET      = 16'd25;
   localparam ticks_type BEEP_TOGGLE_RESET    = 16'd6;
   localparam hz_type    TONE_MIN_RESET       = 15'd1000;
   localparam hz_type    TONE_MAX_RESET       = 15'd4000;

   localparam hz_type    ALARM_TONE_HZ = 15'd2000;
   localparam speed_type SPEED_MAX     = 7'd100;
   localparam green_type GREEN_SCALE   = 10'd10;

   // x / 100 == (x * TONE_RECIP) >> TONE_SHIFT for every x below 2^22
   localparam int           TONE_SHIFT = 29;
   localparam logic [22:0]  TONE_RECIP = 23'd5368710;

   function automatic timer_type timer_step(timer_type t);
      return (t != '1) ? t + timer_type'(1) : t;
   endfunction

endpackage

// ===== hw/rtl/dos_req_if.sv =====
// Request channel interface: one control tick per request
`timescale 1ns / 1ps
interface dos_req_if;
   import dos_pkg::*;

   logic      valid;
   logic      ready;
   logic      button_held;
   logic      pir_raw;
   logic      tilt_sense;
   speed_type speed_pct;
   logic      ack_seen;

   modport source (output valid, button_held, pir_raw, tilt_sense, speed_pct, ack_seen,
                   input ready);
   modport sink   (input valid, button_held, pir_raw, tilt_sense, speed_pct, ack_seen,
                   output ready);
endinterface

// ===== hw/rtl/dos_rsp_if.sv =====
// Result channel interface: LED, buzzer and message flags per request
`timescale 1ns / 1ps
interface dos_rsp_if;
   import dos_pkg::*;

   logic      valid;
   logic      ready;
   logic      red_led;
   logic      blue_led;
   green_type green_level;
   logic      buzzer_enable;
   hz_type    buzzer_hz;
   logic      send_ready_event;
   logic      send_stop_event;
   logic      send_emergency;
   logic      send_speed;
   speed_type speed_value;
   logic      send_alive;

   modport source (output valid, red_led, blue_led, green_level, buzzer_enable, buzzer_hz,
                   send_ready_event, send_stop_event, send_emergency, send_speed,
                   speed_value, send_alive,
                   input ready);
   modport sink   (input valid, red_led, blue_led, green_level, buzzer_enable, buzzer_hz,
                   send_ready_event, send_stop_event, send_emergency, send_speed,
                   speed_value, send_alive,
                   output ready);
endinterface

// ===== hw/rtl/dos_debounce.sv =====
// Consecutive-sample debounce filter for one sensor level
`timescale 1ns / 1ps
module dos_debounce (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                raw,
   input  dos_pkg::count_type  stable_samples,
   output logic                level_next
);
   import dos_pkg::*;

   logic      level_ff, level_in;
   count_type count_ff, count_in;
   count_type count_inc;

   always_comb begin
      level_in  = level_ff;
      count_in  = count_ff;
      count_inc = (count_ff < stable_samples) ? count_ff + count_type'(1) : count_ff;
      if (step) begin
         if (raw == level_ff) begin
            count_in = '0;
         end else if (count_inc >= stable_samples) begin
            count_in = '0;
            level_in = raw;
         end else begin
            count_in = count_inc;
         end
      end
   end

   assign level_next = level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         level_ff <= level_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/deadman_operator_supervisor.sv =====
// Top level: deadman operator supervisor, one control tick per request
//
//   channel | dir | handshake      | carries
//   req     | in  | valid/ready    | button, PIR, tilt, speed percent, ack
//   rsp     | out | valid/ready    | LEDs, buzzer, message flags, speed value
//   csr     | in  | write enable   | register index and 16-bit write data
//
// Two register stages: the request register (tone product formed on entry)
// and the result register (debounce, timers, presence and buzzer update).
// One request per cycle sustained while the result is not stalled.
// A stalled result still lets one more request into the request register.
// Synchronous reset clears control state, not payloads, and loads defaults.
`timescale 1ns / 1ps
`include "deadman_operator_supervisor_assert.svh"
module deadman_operator_supervisor (
   input  logic                    clock,
   input  logic                    reset,
   dos_req_if.sink                 req,
   dos_rsp_if.source               rsp,
   input  logic                    csr_wr_en,
   input  dos_pkg::csr_index_type  csr_index,
   input  dos_pkg::csr_data_type   csr_wdata
);
   import dos_pkg::*;

   // configuration
   cfg_type cfg_ff, cfg_in;

   // request register
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_btn_ff, s1_pir_ff, s1_tilt_ff, s1_ack_ff;
   speed_type     s1_spd_ff;
   logic          s1_tone_up_ff;
   tone_prod_type s1_prod_ff;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   // supervisor state
   logic      button_prev_ff, button_prev_in;
   ticks_type tsp_ff, tsp_in;
   logic      mute_ff, mute_in;
   logic      present_prev_ff, present_prev_in;
   logic      armed_ff, armed_in;
   logic      ack_pending_ff, ack_pending_in;
   logic      ack_latched_ff, ack_latched_in;
   timer_type speed_timer_ff, speed_timer_in;
   timer_type alive_timer_ff, alive_timer_in;
   timer_type retry_timer_ff, retry_timer_in;
   timer_type beep_timer_ff, beep_timer_in;
   logic      beep_phase_ff, beep_phase_in;
   logic      buz_on_ff, buz_on_in;
   hz_type    buz_tone_ff, buz_tone_in;

   logic          accept, s2_load_ok, s1_adv;
   logic          pir_next, tilt_next;
   speed_type     spd_sat;
   logic          tone_up;
   hz_type        tone_diff;
   logic [44:0]   tone_full;
   hz_type        tone_quot;
   hz_type        tone_f;

   // handshake
   assign s2_load_ok = !rsp_valid_ff || rsp.ready;
   assign s1_adv     = s1_valid_ff && s2_load_ok;
   assign req.ready  = !s1_valid_ff || s2_load_ok;
   assign accept     = req.valid && req.ready;

   assign s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // request stage: saturate speed and form the tone slope product
   assign spd_sat   = (req.speed_pct > SPEED_MAX) ? SPEED_MAX : req.speed_pct;
   assign tone_up   = cfg_ff.tone_max_hz >= cfg_ff.tone_min_hz;
   assign tone_diff = tone_up ? cfg_ff.tone_max_hz - cfg_ff.tone_min_hz
                              : cfg_ff.tone_min_hz - cfg_ff.tone_max_hz;

   // csr writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STABLE_SAMPLES: cfg_in.stable_samples     = csr_wdata[3:0];
            CSR_DOUBLE_TAP:     cfg_in.double_tap_ticks   = csr_wdata;
            CSR_SPEED_REPORT:   cfg_in.speed_report_ticks = csr_wdata;
            CSR_ALIVE_REPORT:   cfg_in.alive_report_ticks = csr_wdata;
            CSR_ACK_RETRY:      cfg_in.ack_retry_ticks    = csr_wdata;
            CSR_BEEP_TOGGLE:    cfg_in.beep_toggle_ticks  = csr_wdata;
            CSR_TONE_MIN:       cfg_in.tone_min_hz        = csr_wdata[14:0];
            CSR_TONE_MAX:       cfg_in.tone_max_hz        = csr_wdata[14:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   dos_debounce u_pir_filter (
      .clock          (clock),
      .reset          (reset),
      .step           (s1_adv),
      .raw            (s1_pir_ff),
      .stable_samples (cfg_ff.stable_samples),
      .level_next     (pir_next)
   );

   dos_debounce u_tilt_filter (
      .clock          (clock),
      .reset          (reset),
      .step           (s1_adv),
      .raw            (s1_tilt_ff),
      .stable_samples (cfg_ff.stable_samples),
      .level_next     (tilt_next)
   );

   // divide by 100 through the reciprocal
   assign tone_full = 45'(s1_prod_ff) * 45'(TONE_RECIP);
   assign tone_quot = tone_full[TONE_SHIFT +: 15];
   assign tone_f    = s1_tone_up_ff ? cfg_ff.tone_min_hz + tone_quot
                                    : cfg_ff.tone_min_hz - tone_quot;

   // result stage: one tick of the supervisor
   always_comb begin
      rsp_data_type r;
      logic         present;

      r               = '0;
      present         = 1'b0;
      rsp_data_in     = rsp_data_ff;
      button_prev_in  = button_prev_ff;
      tsp_in          = tsp_ff;
      mute_in         = mute_ff;
      present_prev_in = present_prev_ff;
      armed_in        = armed_ff;
      ack_pending_in  = ack_pending_ff;
      ack_latched_in  = ack_latched_ff;
      speed_timer_in  = speed_timer_ff;
      alive_timer_in  = alive_timer_ff;
      retry_timer_in  = retry_timer_ff;
      beep_timer_in   = beep_timer_ff;
      beep_phase_in   = beep_phase_ff;
      buz_on_in       = buz_on_ff;
      buz_tone_in     = buz_tone_ff;

      if (s1_adv) begin
         if (s1_ack_ff) begin
            ack_latched_in = 1'b1;
         end
         present = s1_btn_ff && pir_next && tilt_next;

         // double tap mute toggle
         tsp_in = (tsp_ff != '1) ? tsp_ff + ticks_type'(1) : tsp_ff;
         if (s1_btn_ff && !button_prev_ff) begin
            if (tsp_in <= cfg_ff.double_tap_ticks) begin
               mute_in = !mute_ff;
            end
            tsp_in = '0;
         end
         button_prev_in = s1_btn_ff;

         // presence transitions
         if (present && !present_prev_ff) begin
            ack_latched_in     = 1'b0;
            ack_pending_in     = 1'b0;
            armed_in           = 1'b1;
            speed_timer_in     = '0;
            alive_timer_in     = '0;
            r.send_ready_event = 1'b1;
         end else if (!present && present_prev_ff) begin
            r.send_stop_event = 1'b1;
            r.send_emergency  = s1_btn_ff;
            ack_pending_in    = 1'b1;
            retry_timer_in    = '0;
            beep_timer_in     = '0;
            beep_phase_in     = 1'b0;
         end
         present_prev_in = present;

         if (present) begin
            r.green_level = green_type'(s1_spd_ff) * GREEN_SCALE;
            if (mute_in) begin
               buz_on_in = 1'b0;
            end else begin
               buz_on_in   = 1'b1;
               buz_tone_in = tone_f;
            end
            speed_timer_in = timer_step(speed_timer_in);
            if (32'(speed_timer_in) >= 32'(cfg_ff.speed_report_ticks)) begin
               speed_timer_in = '0;
               r.send_speed   = 1'b1;
               r.speed_value  = s1_spd_ff;
            end
            alive_timer_in = timer_step(alive_timer_in);
            if (32'(alive_timer_in) >= 32'(cfg_ff.alive_report_ticks)) begin
               alive_timer_in = '0;
               r.send_alive   = 1'b1;
            end
         end else begin
            r.red_led  = 1'b1;
            r.blue_led = pir_next;
            if (armed_in && !mute_in) begin
               beep_timer_in = timer_step(beep_timer_in);
               if (32'(beep_timer_in) >= 32'(cfg_ff.beep_toggle_ticks)) begin
                  beep_timer_in = '0;
                  beep_phase_in = !beep_phase_in;
                  if (beep_phase_in) begin
                     buz_on_in   = 1'b1;
                     buz_tone_in = ALARM_TONE_HZ;
                  end else begin
                     buz_on_in = 1'b0;
                  end
               end
            end else begin
               buz_on_in = 1'b0;
            end
            if (ack_pending_in) begin
               if (ack_latched_in) begin
                  ack_latched_in = 1'b0;
                  ack_pending_in = 1'b0;
               end else begin
                  retry_timer_in = timer_step(retry_timer_in);
                  if (32'(retry_timer_in) >= 32'(cfg_ff.ack_retry_ticks)) begin
                     retry_timer_in    = '0;
                     r.send_stop_event = 1'b1;
                  end
               end
            end
         end

         r.buzzer_enable = buz_on_in;
         r.buzzer_hz     = buz_on_in ? buz_tone_in : '0;
         rsp_data_in     = r;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stable_samples     <= STABLE_SAMPLES_RESET;
         cfg_ff.double_tap_ticks   <= DOUBLE_TAP_RESET;
         cfg_ff.speed_report_ticks <= SPEED_REPORT_RESET;
         cfg_ff.alive_report_ticks <= ALIVE_REPORT_RESET;
         cfg_ff.ack_retry_ticks    <= ACK_RETRY_RESET;
         cfg_ff.beep_toggle_ticks  <= BEEP_TOGGLE_RESET;
         cfg_ff.tone_min_hz        <= TONE_MIN_RESET;
         cfg_ff.tone_max_hz        <= TONE_MAX_RESET;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         button_prev_ff  <= 1'b0;
         tsp_ff          <= '0;
         mute_ff         <= 1'b0;
         present_prev_ff <= 1'b0;
         armed_ff        <= 1'b0;
         ack_pending_ff  <= 1'b0;
         ack_latched_ff  <= 1'b0;
         speed_timer_ff  <= '0;
         alive_timer_ff  <= '0;
         retry_timer_ff  <= '0;
         beep_timer_ff   <= '0;
         beep_phase_ff   <= 1'b0;
         buz_on_ff       <= 1'b0;
         buz_tone_ff     <= '0;
      end else begin
         cfg_ff          <= cfg_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         button_prev_ff  <= button_prev_in;
         tsp_ff          <= tsp_in;
         mute_ff         <= mute_in;
         present_prev_ff <= present_prev_in;
         armed_ff        <= armed_in;
         ack_pending_ff  <= ack_pending_in;
         ack_latched_ff  <= ack_latched_in;
         speed_timer_ff  <= speed_timer_in;
         alive_timer_ff  <= alive_timer_in;
         retry_timer_ff  <= retry_timer_in;
         beep_timer_ff   <= beep_timer_in;
         beep_phase_ff   <= beep_phase_in;
         buz_on_ff       <= buz_on_in;
         buz_tone_ff     <= buz_tone_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         s1_btn_ff     <= req.button_held;
         s1_pir_ff     <= req.pir_raw;
         s1_tilt_ff    <= req.tilt_sense;
         s1_ack_ff     <= req.ack_seen;
         s1_spd_ff     <= spd_sat;
         s1_tone_up_ff <= tone_up;
         s1_prod_ff    <= tone_prod_type'(tone_diff) * tone_prod_type'(spd_sat);
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.red_led          = rsp_data_ff.red_led;
   assign rsp.blue_led         = rsp_data_ff.blue_led;
   assign rsp.green_level      = rsp_data_ff.green_level;
   assign rsp.buzzer_enable    = rsp_data_ff.buzzer_enable;
   assign rsp.buzzer_hz        = rsp_data_ff.buzzer_hz;
   assign rsp.send_ready_event = rsp_data_ff.send_ready_event;
   assign rsp.send_stop_event  = rsp_data_ff.send_stop_event;
   assign rsp.send_emergency   = rsp_data_ff.send_emergency;
   assign rsp.send_speed       = rsp_data_ff.send_speed;
   assign rsp.speed_value      = rsp_data_ff.speed_value;
   assign rsp.send_alive       = rsp_data_ff.send_alive;

   `DOS_ASSERT_IMPLY(a_pending_needs_arm, ack_pending_ff, armed_ff, "ack pending before arming")
   `DOS_ASSERT_IMPLY(a_absent_no_green, rsp.valid && rsp.red_led, rsp.green_level == '0, "green lit while absent")
   `DOS_ASSERT_IMPLY(a_ready_stop_excl, rsp.valid && rsp.send_ready_event, !rsp.send_stop_event, "ready and stop together")
   `DOS_ASSERT_IMPLY(a_quiet_tone_zero, rsp.valid && !rsp.buzzer_enable, rsp.buzzer_hz == '0, "tone while buzzer off")
   `DOS_ASSERT_NEXT(a_advance_gives_rsp, s1_adv, rsp_valid_ff, "request advanced without result")

endmodule
